@@ rtl/gsu_pkg.sv @@
// shared types and constants of the graph segment union merge block
package gsu_pkg;
  localparam int NODE_BITS        = 16;
  localparam int WEIGHT_BITS      = 13;
  localparam int SIZE_BITS        = 17;
  localparam int RANK_BITS        = 5;
  localparam int K_BITS           = 10;
  localparam int WEIGHT_FRAC_BITS = 4;
  localparam int CFG_INDEX_BITS   = 1;

  localparam logic [RANK_BITS-1:0] RANK_MAX = '1;

  typedef enum logic [1:0] {
    REQ_THRESH = 2'd0,
    REQ_SMALL  = 2'd1,
    REQ_QUERY  = 2'd2,
    REQ_SPARE  = 2'd3
  } req_t;

  localparam logic [CFG_INDEX_BITS-1:0] CFG_K_SCALE  = 1'd0;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_MIN_SIZE = 1'd1;

  // per-root record kept beside the parent pointer
  typedef struct packed {
    logic [RANK_BITS-1:0]   rank;
    logic [SIZE_BITS-1:0]   size;
    logic [WEIGHT_BITS-1:0] maxw;
  } info_t;

  localparam int INFO_BITS = $bits(info_t);
endpackage

@@ rtl/gsu_ram.sv @@
// single-port-write, single-port-read ram with registered read data
module gsu_ram #(
  parameter int WIDTH     = 16,
  parameter int ADDR_BITS = 16
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [ADDR_BITS-1:0] waddr,
  input  logic [WIDTH-1:0]     wdata,
  input  logic [ADDR_BITS-1:0] raddr,
  output logic [WIDTH-1:0]     rdata
);
  logic [WIDTH-1:0] mem [2**ADDR_BITS];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

@@ rtl/graph_segment_union_merge.sv @@
// top level: union-find forest over pixel nodes with threshold and small-component merges
//
// s_* carries one request per beat: tuser holds req_type, tdata holds node_a, node_b
// and weight. m_* returns exactly one result per request: tuser holds merged, tdata
// holds root_label and component_size. cfg_we/cfg_index/cfg_data write k_scale (0)
// and min_size (1) at any rising edge; write them only while the block is idle.
// Requests are handled one at a time. A query runs one find; a threshold or small
// merge request runs a second find for node_b and, when it joins two components,
// also the ST_WR1 and ST_WR2 writes. Each find walks the parent chain with one read
// of the parent ram per link and then rewrites the same links for path compression,
// and the two root records are read from a second ram, checked, and written back
// when the two components are joined.
// After rst the block sweeps every address of both rams to restore every node as
// its own root; s_tready stays low during that sweep. The result sits in an output
// register, so a stalled receiver does not block the next request from starting;
// the block only waits when a new result is ready and the old one is not yet taken.
module graph_segment_union_merge (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_tvalid,
  output logic                             s_tready,
  input  logic [47:0]                      s_tdata,  // node_a, node_b, weight, zero pad
  input  logic [1:0]                       s_tuser,  // req_type
  output logic                             m_tvalid,
  input  logic                             m_tready,
  output logic [39:0]                      m_tdata,  // root_label, component_size, zero pad
  output logic [0:0]                       m_tuser,  // merged
  input  logic                             cfg_we,
  input  logic [gsu_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [gsu_pkg::SIZE_BITS-1:0]    cfg_data
);
  import gsu_pkg::*;

  typedef enum logic [3:0] {
    ST_CLR, ST_IDLE, ST_FIND_RD, ST_FIND_CHK, ST_CMP_RD, ST_CMP_WR,
    ST_INFO_U, ST_INFO_V, ST_EVAL, ST_WR1, ST_WR2, ST_DONE
  } state_t;

  state_t                 state;
  logic [NODE_BITS-1:0]   clr_addr;
  logic [K_BITS-1:0]      k_scale;
  logic [SIZE_BITS-1:0]   min_size;
  req_t                   req;
  logic [NODE_BITS-1:0]   node_b;
  logic [WEIGHT_BITS-1:0] weight;
  logic                   phase_b;
  logic [NODE_BITS-1:0]   cur;
  logic [NODE_BITS-1:0]   start;
  logic [NODE_BITS-1:0]   root;
  logic [NODE_BITS-1:0]   root_u;
  logic [NODE_BITS-1:0]   root_v;
  info_t                  info_u;
  logic                   merge;
  logic [NODE_BITS-1:0]   par_node;
  logic [NODE_BITS-1:0]   kid_node;
  info_t                  par_info;
  info_t                  kid_info;

  logic                   p_we;
  logic [NODE_BITS-1:0]   p_waddr;
  logic [NODE_BITS-1:0]   p_wdata;
  logic [NODE_BITS-1:0]   p_raddr;
  logic [NODE_BITS-1:0]   p_rdata;
  logic                   i_we;
  logic [NODE_BITS-1:0]   i_waddr;
  info_t                  i_wdata;
  logic [NODE_BITS-1:0]   i_raddr;
  logic [INFO_BITS-1:0]   i_rdata;

  gsu_ram #(.WIDTH(NODE_BITS), .ADDR_BITS(NODE_BITS)) u_parent (
    .clk(clk), .we(p_we), .waddr(p_waddr), .wdata(p_wdata),
    .raddr(p_raddr), .rdata(p_rdata)
  );

  gsu_ram #(.WIDTH(INFO_BITS), .ADDR_BITS(NODE_BITS)) u_info (
    .clk(clk), .we(i_we), .waddr(i_waddr), .wdata(i_wdata),
    .raddr(i_raddr), .rdata(i_rdata)
  );

  // threshold test for both roots, exact in fixed point
  info_t                          info_vr;
  logic [WEIGHT_BITS-1:0]         diff_u;
  logic [WEIGHT_BITS-1:0]         diff_v;
  logic [WEIGHT_BITS+SIZE_BITS-1:0] prod_u;
  logic [WEIGHT_BITS+SIZE_BITS-1:0] prod_v;
  logic [WEIGHT_BITS+SIZE_BITS-1:0] slack;
  logic                           pass_u;
  logic                           pass_v;
  logic                           distinct;
  logic                           do_thresh;
  logic                           do_small;
  logic [SIZE_BITS-1:0]           size_sum;

  assign info_vr  = info_t'(i_rdata);
  assign diff_u   = weight - info_u.maxw;
  assign diff_v   = weight - info_vr.maxw;
  assign prod_u   = diff_u * info_u.size;
  assign prod_v   = diff_v * info_vr.size;
  assign slack    = (WEIGHT_BITS+SIZE_BITS)'(k_scale) << WEIGHT_FRAC_BITS;
  assign pass_u   = (weight <= info_u.maxw) || (prod_u <= slack);
  assign pass_v   = (weight <= info_vr.maxw) || (prod_v <= slack);
  assign distinct = root_u != root_v;
  assign do_thresh = (req == REQ_THRESH) && distinct && pass_u && pass_v;
  assign do_small  = (req == REQ_SMALL) && distinct &&
                     ((info_u.size < min_size) || (info_vr.size < min_size));
  assign size_sum = info_u.size + info_vr.size;

  always_comb begin
    p_we    = 1'b0;
    p_waddr = cur;
    p_wdata = root;
    p_raddr = cur;
    i_we    = 1'b0;
    i_waddr = par_node;
    i_wdata = par_info;
    i_raddr = root_u;
    case (state)
      ST_CLR: begin
        p_we    = 1'b1;
        p_waddr = clr_addr;
        p_wdata = clr_addr;
        i_we    = 1'b1;
        i_waddr = clr_addr;
        i_wdata = '{rank: RANK_BITS'(1), size: SIZE_BITS'(1), maxw: '0};
      end
      ST_CMP_WR: p_we = 1'b1;
      ST_INFO_V: i_raddr = root_v;
      ST_WR1: begin
        p_we    = 1'b1;
        p_waddr = kid_node;
        p_wdata = par_node;
      end
      ST_WR2: begin
        i_we    = 1'b1;
        i_waddr = kid_node;
        i_wdata = kid_info;
      end
      default: ;
    endcase
    if (state == ST_WR1) begin
      i_we = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_CLR;
      clr_addr <= '0;
      k_scale  <= K_BITS'(10);
      min_size <= SIZE_BITS'(2000);
      m_tvalid <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_K_SCALE:  k_scale  <= cfg_data[K_BITS-1:0];
          CFG_MIN_SIZE: min_size <= cfg_data;
          default: ;
        endcase
      end
      // in ST_DONE the load below takes care of a beat taken in the same cycle
      if (m_tvalid && m_tready && state != ST_DONE) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        ST_CLR: begin
          clr_addr <= clr_addr + 1'b1;
          if (&clr_addr) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (s_tvalid) begin
            req     <= req_t'(s_tuser);
            cur     <= s_tdata[15:0];
            start   <= s_tdata[15:0];
            node_b  <= s_tdata[31:16];
            weight  <= s_tdata[44:32];
            phase_b <= 1'b0;
            state   <= ST_FIND_RD;
          end
        end
        ST_FIND_RD: state <= ST_FIND_CHK;
        ST_FIND_CHK: begin
          if (p_rdata == cur) begin
            root  <= cur;
            cur   <= start;
            state <= ST_CMP_RD;
          end else begin
            cur   <= p_rdata;
            state <= ST_FIND_RD;
          end
        end
        ST_CMP_RD: begin
          if (cur == root) begin
            if (phase_b) begin
              root_v <= root;
              state  <= ST_INFO_U;
            end else begin
              root_u <= root;
              if (req == REQ_THRESH || req == REQ_SMALL) begin
                phase_b <= 1'b1;
                cur     <= node_b;
                start   <= node_b;
                state   <= ST_FIND_RD;
              end else begin
                root_v <= root;
                state  <= ST_INFO_U;
              end
            end
          end else begin
            state <= ST_CMP_WR;
          end
        end
        ST_CMP_WR: begin
          cur   <= p_rdata;
          state <= ST_CMP_RD;
        end
        ST_INFO_U: state <= ST_INFO_V;
        ST_INFO_V: begin
          info_u <= info_t'(i_rdata);
          state  <= ST_EVAL;
        end
        ST_EVAL: begin
          merge  <= do_thresh || do_small;
          if (do_small || (do_thresh && info_vr.rank < info_u.rank)) begin
            par_node <= root_u;
            kid_node <= root_v;
            par_info <= '{rank: info_u.rank, size: size_sum,
                          maxw: do_thresh ? weight : info_u.maxw};
            kid_info <= '{rank: info_vr.rank, size: '0, maxw: info_vr.maxw};
          end else begin
            par_node <= root_v;
            kid_node <= root_u;
            par_info <= '{rank: (info_u.rank == info_vr.rank && info_vr.rank != RANK_MAX)
                                ? info_vr.rank + 1'b1 : info_vr.rank,
                          size: size_sum, maxw: weight};
            kid_info <= '{rank: info_u.rank, size: '0, maxw: info_u.maxw};
          end
          state <= (do_thresh || do_small) ? ST_WR1 : ST_DONE;
        end
        ST_WR1: state <= ST_WR2;
        ST_WR2: state <= ST_DONE;
        ST_DONE: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tuser  <= merge;
            m_tdata  <= {7'd0, (merge ? par_info.size : info_u.size),
                         (merge ? par_node : root_u)};
            state    <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
      if (state == ST_INFO_U) begin
        merge <= 1'b0;
      end
    end
  end

  assign s_tready = (state == ST_IDLE);

  // compression only ever points a node at the root just found
  a_cmp_root: assert property (@(posedge clk) disable iff (rst)
    (state == ST_CMP_WR) |-> (p_we && p_wdata == root))
    else $error("compression write not to found root");

  // a joined component holds at least two nodes
  a_merge_size: assert property (@(posedge clk) disable iff (rst)
    (state == ST_WR1) |-> (par_info.size >= SIZE_BITS'(2) && par_node != kid_node))
    else $error("bad merge record");

  // no request is taken during the reset sweep
  a_clr_block: assert property (@(posedge clk) disable iff (rst)
    (state == ST_CLR) |-> !s_tready)
    else $error("request taken during sweep");

  // a result is only loaded once the previous one is gone
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready && state == ST_DONE) |=> (state == ST_DONE))
    else $error("result overwritten");
endmodule
